FILE: hdl/rpa_pkg.sv
// Shared types, codes and the rainbow step function of the rainbow pixel animator.
// No dependencies; every other file of the block imports this package.
package rpa_pkg;

    localparam int DEFAULT_PIXELS = 256;
    // Wide enough to hold any pixel count of the supported range (up to 4096).
    localparam int IDX_EXT_W = 13;

    localparam logic [7:0] CHAN_MAX = 8'hFF;
    localparam logic [7:0] RST_ADVANCE_STEP = 8'd1;
    localparam logic [7:0] RST_SEED_STEP = 8'd2;

    typedef enum logic [1:0] {
        CMD_ADVANCE      = 2'd0,
        CMD_SEED_RAINBOW = 2'd1,
        CMD_SEED_BLACK   = 2'd2,
        CMD_READ         = 2'd3
    } t_cmd;

    typedef enum logic [0:0] {
        REG_ADVANCE_STEP = 1'b0,
        REG_SEED_STEP    = 1'b1
    } t_reg_idx;

    localparam logic [2:0] PHASE_RED_UP     = 3'd0;
    localparam logic [2:0] PHASE_BLUE_DOWN  = 3'd1;
    localparam logic [2:0] PHASE_GREEN_UP   = 3'd2;
    localparam logic [2:0] PHASE_RED_DOWN   = 3'd3;
    localparam logic [2:0] PHASE_BLUE_UP    = 3'd4;
    localparam logic [2:0] PHASE_GREEN_DOWN = 3'd5;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] pixel_index;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [2:0] phase;
    } t_out_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [2:0] phase;
    } t_pixel;

    // Controller to datapath.
    typedef struct packed {
        logic load;    // input beat accepted: capture it and read the store
        logic update;  // compute, write back and fill the result register
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_busy;  // result register holds a beat that is not taken this cycle
    } t_dp_sts;

    function automatic logic [7:0] ramp_up_val(input logic [7:0] ch, input logic [7:0] step);
        logic [8:0] sum;
        sum = {1'b0, ch} + {1'b0, step};
        ramp_up_val = sum[8] ? CHAN_MAX : sum[7:0];
    endfunction

    function automatic logic ramp_up_done(input logic [7:0] ch, input logic [7:0] step);
        logic [8:0] sum;
        sum = {1'b0, ch} + {1'b0, step};
        ramp_up_done = sum[8];
    endfunction

    function automatic logic [7:0] ramp_down_val(input logic [7:0] ch,
                                                 input logic [7:0] step);
        ramp_down_val = (ch > step) ? (ch - step) : 8'd0;
    endfunction

    // One rainbow step: ramp the channel of the current phase and move on at saturation.
    function automatic t_pixel rainbow_step(input t_pixel p, input logic [7:0] step);
        t_pixel q;
        q = p;
        case (p.phase)
            PHASE_RED_UP: begin
                q.red = ramp_up_val(p.red, step);
                if (ramp_up_done(p.red, step)) q.phase = PHASE_BLUE_DOWN;
            end
            PHASE_BLUE_DOWN: begin
                q.blue = ramp_down_val(p.blue, step);
                if (!(p.blue > step)) q.phase = PHASE_GREEN_UP;
            end
            PHASE_GREEN_UP: begin
                q.green = ramp_up_val(p.green, step);
                if (ramp_up_done(p.green, step)) q.phase = PHASE_RED_DOWN;
            end
            PHASE_RED_DOWN: begin
                q.red = ramp_down_val(p.red, step);
                if (!(p.red > step)) q.phase = PHASE_BLUE_UP;
            end
            PHASE_BLUE_UP: begin
                q.blue = ramp_up_val(p.blue, step);
                if (ramp_up_done(p.blue, step)) q.phase = PHASE_GREEN_DOWN;
            end
            PHASE_GREEN_DOWN: begin
                q.green = ramp_down_val(p.green, step);
                if (!(p.green > step)) q.phase = PHASE_RED_UP;
            end
            default: q.phase = PHASE_RED_UP;
        endcase
        rainbow_step = q;
    endfunction

endpackage

FILE: hdl/rpa_ctrl.sv
// Sequencing controller of the rainbow pixel animator: accept, store read, update.
// Depends on rpa_pkg for the command and status structs.
module rpa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rpa_pkg::t_dp_sts  i_sts,
    output rpa_pkg::t_dp_cmd  o_cmd
);
    import rpa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_UPDATE
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   load;
    logic   update;

    assign load   = i_in_valid && r_in_ready;
    assign update = (r_state == S_UPDATE) && !i_sts.out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_in_ready <= !load;
                    if (load) r_state <= S_READ;
                end
                S_READ: begin
                    r_in_ready <= 1'b0;
                    r_state    <= S_UPDATE;
                end
                S_UPDATE: begin
                    r_in_ready <= update;
                    if (update) r_state <= S_IDLE;
                end
                default: begin
                    r_in_ready <= 1'b0;
                    r_state    <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready   = r_in_ready;
    assign o_cmd.load   = load;
    assign o_cmd.update = update;

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ready |-> (r_state == S_IDLE))
        else $error("input ready outside the idle state");

    a_load_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_state == S_READ) && !r_in_ready)
        else $error("accepted beat did not start a store read");

    a_read_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_UPDATE))
        else $error("store read not followed by update");

    a_no_update_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.out_busy |-> !update)
        else $error("update while the result register is occupied");

endmodule

FILE: hdl/rpa_datapath.sv
// Datapath of the rainbow pixel animator: pixel store, seed generator, step logic,
// configuration registers and result register. Depends on rpa_pkg.
module rpa_datapath #(
    parameter int PIXELS = rpa_pkg::DEFAULT_PIXELS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rpa_pkg::t_dp_cmd     i_cmd,
    output rpa_pkg::t_dp_sts     o_sts,
    input  rpa_pkg::t_in_item    i_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output rpa_pkg::t_out_item   o_out_item,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data
);
    import rpa_pkg::*;

    localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;

    t_pixel r_mem [PIXELS];

    logic [7:0]           r_advance_step;
    logic [7:0]           r_seed_step;
    t_pixel               r_gen;
    t_pixel               r_rd_data;
    t_cmd                 r_cmd;
    logic [7:0]           r_idx;
    logic [ADDR_W-1:0]    r_addr;
    logic                 r_in_range;
    logic                 r_out_valid;
    t_out_item            r_out_item;

    logic [IDX_EXT_W-1:0] idx_ext;
    logic                 in_range;
    logic                 idx_zero;
    t_pixel               gen_base;
    t_pixel               gen_next;
    t_pixel               new_pix;
    logic                 mem_we;

    assign idx_ext  = IDX_EXT_W'(i_item.pixel_index);
    assign in_range = idx_ext < IDX_EXT_W'(PIXELS);
    assign idx_zero = (r_idx == 8'd0);

    // A rainbow seed at pixel zero restarts the generator from black before stepping.
    assign gen_base = idx_zero ? t_pixel'('0) : r_gen;
    assign gen_next = rainbow_step(gen_base, r_seed_step);

    always_comb begin
        case (r_cmd)
            CMD_ADVANCE:      new_pix = rainbow_step(r_rd_data, r_advance_step);
            CMD_SEED_RAINBOW: new_pix = gen_next;
            CMD_SEED_BLACK:   new_pix = '0;
            default:          new_pix = r_rd_data;
        endcase
    end

    assign mem_we = i_cmd.update && r_in_range && (r_cmd != CMD_READ);

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[r_addr] <= new_pix;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_data  <= r_mem[idx_ext[ADDR_W-1:0]];
            r_cmd      <= i_item.command;
            r_idx      <= i_item.pixel_index;
            r_addr     <= idx_ext[ADDR_W-1:0];
            r_in_range <= in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_advance_step <= RST_ADVANCE_STEP;
            r_seed_step    <= RST_SEED_STEP;
            r_gen          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ADVANCE_STEP: r_advance_step <= i_cfg_data;
                    REG_SEED_STEP:    r_seed_step    <= i_cfg_data;
                    default:          r_seed_step    <= r_seed_step;
                endcase
            end
            if (i_cmd.update && r_in_range) begin
                if (r_cmd == CMD_SEED_RAINBOW) begin
                    r_gen <= gen_next;
                end else if (r_cmd == CMD_SEED_BLACK && idx_zero) begin
                    r_gen <= '0;
                end
            end
            if (i_cmd.update) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_out_item.out_index <= r_idx;
            r_out_item.red       <= r_in_range ? new_pix.red   : 8'd0;
            r_out_item.green     <= r_in_range ? new_pix.green : 8'd0;
            r_out_item.blue      <= r_in_range ? new_pix.blue  : 8'd0;
            r_out_item.phase     <= r_in_range ? new_pix.phase : 3'd0;
        end
    end

    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out_item;

    a_update_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |=> r_out_valid)
        else $error("update did not present a result beat");

    a_out_of_range_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && !r_in_range) |=> (r_out_item.phase == 3'd0)
            && (r_out_item.red == 8'd0) && (r_out_item.green == 8'd0)
            && (r_out_item.blue == 8'd0))
        else $error("out-of-range pixel produced a nonzero result");

    a_gen_phase_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gen.phase <= PHASE_GREEN_DOWN)
        else $error("seed generator left the six rainbow phases");

endmodule

FILE: hdl/rainbow_pixel_animator.sv
// Rainbow pixel animator, top level: joins the controller and the datapath.
// Depends on rpa_pkg, rpa_ctrl and rpa_datapath.
//
// Each input beat carries a command and a pixel index and yields exactly one result
// beat with the pixel's color and rainbow phase after the command. The accepting edge
// also reads the addressed pixel store entry into a register (a single-port memory with
// a registered read). The next cycle is a spare read stage. In the cycle after that the
// rainbow step is computed, and the entry is written back and the result register
// filled at the closing edge of the update. Ready drops at acceptance and returns only
// after that update, so the block takes no new beat until the last one is updated.
// The update waits while an earlier result beat has not been taken, and that wait
// delays the next acceptance. The result register lets the next beat be accepted
// while the previous result still waits to be taken.
// Pixels must be seeded before they are read or advanced; the store needs no clearing
// after reset. Indices at or above PIXELS return black, phase zero, and change nothing.
module rainbow_pixel_animator #(
    parameter int PIXELS = rpa_pkg::DEFAULT_PIXELS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rpa_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rpa_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data
);
    import rpa_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    rpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    rpa_datapath #(
        .PIXELS (PIXELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_item      (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the rainbow pixel animator: directed table, then random traffic.
// Depends on rpa_pkg and rainbow_pixel_animator; expected beats come from the plan or an in-bench predictor.
`timescale 1ns / 1ps

module tb_top;
    import rpa_pkg::*;

    localparam int PIXELS      = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 120;

    typedef enum logic [1:0] {
        ROW_PREDICT = 2'd0,
        ROW_LITERAL = 2'd1,
        ROW_REG     = 2'd2
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        t_in_item   beat;
        t_reg_idx   reg_sel;
        logic [7:0] reg_val;
        t_out_item  want;
    } t_plan_row;

    localparam t_out_item NO_WANT = '0;
    localparam t_in_item  NO_BEAT = '0;
    localparam int PLAN_ROWS = 28;

    // Directed opening: reset steps, generator restarts, saturation at both extremes,
    // a full trip round the color wheel and a step of zero.
    t_plan_row plan [PLAN_ROWS] = '{
        '{ROW_LITERAL, '{CMD_SEED_BLACK, 8'd0}, REG_ADVANCE_STEP, 8'd0,
          '{8'd0, 8'd0, 8'd0, 8'd0, PHASE_RED_UP}},
        '{ROW_LITERAL, '{CMD_SEED_RAINBOW, 8'd0}, REG_ADVANCE_STEP, 8'd0,
          '{8'd0, 8'd2, 8'd0, 8'd0, PHASE_RED_UP}},
        '{ROW_LITERAL, '{CMD_SEED_RAINBOW, 8'd255}, REG_ADVANCE_STEP, 8'd0,
          '{8'd255, 8'd4, 8'd0, 8'd0, PHASE_RED_UP}},
        '{ROW_LITERAL, '{CMD_READ, 8'd255}, REG_ADVANCE_STEP, 8'd0,
          '{8'd255, 8'd4, 8'd0, 8'd0, PHASE_RED_UP}},
        '{ROW_LITERAL, '{CMD_ADVANCE, 8'd255}, REG_ADVANCE_STEP, 8'd0,
          '{8'd255, 8'd5, 8'd0, 8'd0, PHASE_RED_UP}},
        '{ROW_LITERAL, '{CMD_SEED_BLACK, 8'd255}, REG_ADVANCE_STEP, 8'd0,
          '{8'd255, 8'd0, 8'd0, 8'd0, PHASE_RED_UP}},
        '{ROW_PREDICT, '{CMD_SEED_RAINBOW, 8'd170}, REG_ADVANCE_STEP, 8'd0, NO_WANT},
        '{ROW_PREDICT, '{CMD_SEED_RAINBOW, 8'd85}, REG_ADVANCE_STEP, 8'd0, NO_WANT},
        '{ROW_PREDICT, '{CMD_ADVANCE, 8'd170}, REG_ADVANCE_STEP, 8'd0, NO_WANT},
        '{ROW_PREDICT, '{CMD_READ, 8'd85}, REG_ADVANCE_STEP, 8'd0, NO_WANT},
        '{ROW_REG, NO_BEAT, REG_ADVANCE_STEP, 8'd255, NO_WANT},
        '{ROW_REG, NO_BEAT, REG_SEED_STEP, 8'd255, NO_WANT},
        '{ROW_PREDICT, '{CMD_ADVANCE, 8'd170}, REG_ADVANCE_STEP, 8'd0, NO_WANT},
        '{ROW_PREDICT, '{CMD_ADVANCE, 8'd170}, REG_ADVANCE_STEP, 8'd0, NO_WANT},
        '{ROW_PREDICT, '{CMD_ADVANCE, 8'd170}, REG_ADVANCE_STEP, 8'd0, NO_WANT},
        '{ROW_PREDICT, '{CMD_ADVANCE, 8'd170}, REG_ADVANCE_STEP, 8'd0, NO_WANT},
        '{ROW_PREDICT, '{CMD_ADVANCE, 8'd170}, REG_ADVANCE_STEP, 8'd0, NO_WANT},
        '{ROW_PREDICT, '{CMD_ADVANCE, 8'd170}, REG_ADVANCE_STEP, 8'd0, NO_WANT},
        '{ROW_LITERAL, '{CMD_SEED_RAINBOW, 8'd0}, REG_ADVANCE_STEP, 8'd0,
          '{8'd0, 8'd255, 8'd0, 8'd0, PHASE_RED_UP}},
        '{ROW_PREDICT, '{CMD_SEED_RAINBOW, 8'd1}, REG_ADVANCE_STEP, 8'd0, NO_WANT},
        '{ROW_LITERAL, '{CMD_SEED_BLACK, 8'd0}, REG_ADVANCE_STEP, 8'd0,
          '{8'd0, 8'd0, 8'd0, 8'd0, PHASE_RED_UP}},
        '{ROW_LITERAL, '{CMD_SEED_RAINBOW, 8'd2}, REG_ADVANCE_STEP, 8'd0,
          '{8'd2, 8'd255, 8'd0, 8'd0, PHASE_RED_UP}},
        '{ROW_PREDICT, '{CMD_READ, 8'd1}, REG_ADVANCE_STEP, 8'd0, NO_WANT},
        '{ROW_LITERAL, '{CMD_READ, 8'd0}, REG_ADVANCE_STEP, 8'd0,
          '{8'd0, 8'd0, 8'd0, 8'd0, PHASE_RED_UP}},
        '{ROW_REG, NO_BEAT, REG_ADVANCE_STEP, 8'd0, NO_WANT},
        '{ROW_PREDICT, '{CMD_ADVANCE, 8'd2}, REG_ADVANCE_STEP, 8'd0, NO_WANT},
        '{ROW_PREDICT, '{CMD_ADVANCE, 8'd2}, REG_ADVANCE_STEP, 8'd0, NO_WANT},
        '{ROW_PREDICT, '{CMD_READ, 8'd170}, REG_ADVANCE_STEP, 8'd0, NO_WANT}
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in_item   in_beat;
    logic       out_valid;
    logic       out_ready;
    t_out_item  out_beat;
    logic       cfg_we;
    logic [0:0] cfg_index;
    logic [7:0] cfg_data;

    // Predictor state: the pixel store, the seed generator and both step registers.
    t_pixel     model_px [PIXELS];
    t_pixel     model_gen;
    logic [7:0] model_adv;
    logic [7:0] model_seed;

    t_out_item  color_q [$];
    logic [7:0] seeded_list [$];
    bit         seeded_map [PIXELS];

    int in_idle_pct;
    int out_idle_pct;
    int sweep_next;
    int sweep_left;
    int hold_left;
    int holds_done;
    int n_beats;
    int n_results;
    int n_fail;
    int n_reg_writes;
    int n_cycles;
    logic [5:0] phases_seen;
    t_out_item  want;

    rainbow_pixel_animator #(.PIXELS(PIXELS)) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // One step round the color wheel: even phases ramp a channel up, odd phases ramp one down.
    function automatic t_pixel wheel_step(t_pixel p, logic [7:0] step);
        t_pixel     q;
        logic [7:0] lvl;
        logic [8:0] sum;
        logic       done;
        q = p;
        if (p.phase > PHASE_GREEN_DOWN) begin
            q.phase = PHASE_RED_UP;
            return q;
        end
        case (p.phase)
            PHASE_RED_UP, PHASE_RED_DOWN:    lvl = p.red;
            PHASE_BLUE_DOWN, PHASE_BLUE_UP:  lvl = p.blue;
            default:                         lvl = p.green;
        endcase
        if (p.phase[0] == 1'b0) begin
            sum  = {1'b0, lvl} + {1'b0, step};
            done = sum[8];
            lvl  = done ? CHAN_MAX : sum[7:0];
        end else begin
            done = (lvl <= step);
            lvl  = done ? 8'd0 : lvl - step;
        end
        case (p.phase)
            PHASE_RED_UP, PHASE_RED_DOWN:    q.red = lvl;
            PHASE_BLUE_DOWN, PHASE_BLUE_UP:  q.blue = lvl;
            default:                         q.green = lvl;
        endcase
        if (done) q.phase = (p.phase == PHASE_GREEN_DOWN) ? PHASE_RED_UP : p.phase + 3'd1;
        return q;
    endfunction

    // Applies one command to the predicted store and returns the color beat it yields.
    function automatic t_out_item pixel_after(t_in_item b);
        t_out_item r;
        t_pixel    px;
        int        idx;
        idx = int'(b.pixel_index);
        case (b.command)
            CMD_ADVANCE: model_px[idx] = wheel_step(model_px[idx], model_adv);
            CMD_SEED_RAINBOW: begin
                if (idx == 0) model_gen = '0;
                model_gen     = wheel_step(model_gen, model_seed);
                model_px[idx] = model_gen;
            end
            CMD_SEED_BLACK: begin
                if (idx == 0) model_gen = '0;
                model_px[idx] = '0;
            end
            default: ;
        endcase
        px          = model_px[idx];
        r.out_index = b.pixel_index;
        r.red       = px.red;
        r.green     = px.green;
        r.blue      = px.blue;
        r.phase     = px.phase;
        return r;
    endfunction

    // Random traffic: mostly advances and reads of pixels already seeded, seeding sweeps
    // that start at pixel 0, and scattered seeds that break the generator's run.
    function automatic t_in_item pick_beat();
        t_in_item b;
        int       roll;
        int       hot;
        roll = $urandom_range(99);
        if (sweep_left == 0 && roll < 3) begin
            sweep_next = 0;
            sweep_left = $urandom_range(40, 1);
        end
        if (sweep_left != 0) begin
            b.command     = CMD_SEED_RAINBOW;
            b.pixel_index = 8'(sweep_next);
            sweep_next++;
            sweep_left--;
        end else if (seeded_list.size() == 0 || roll < 12) begin
            b.command     = (roll < 9) ? CMD_SEED_RAINBOW : CMD_SEED_BLACK;
            b.pixel_index = 8'($urandom_range(255));
        end else if (roll < 75) begin
            b.command = CMD_ADVANCE;
            hot       = (seeded_list.size() < 4) ? seeded_list.size() - 1 : 3;
            if ($urandom_range(1) == 0)
                b.pixel_index = seeded_list[$urandom_range(hot)];
            else
                b.pixel_index = seeded_list[$urandom_range(seeded_list.size() - 1)];
        end else begin
            b.command     = CMD_READ;
            b.pixel_index = seeded_list[$urandom_range(seeded_list.size() - 1)];
        end
        return b;
    endfunction

    // Offers one beat, holds it until accepted, and queues the color it should produce.
    task automatic offer_beat(input t_in_item b, input bit literal, input t_out_item lit_want);
        t_out_item predicted;
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        if ((b.command == CMD_SEED_RAINBOW || b.command == CMD_SEED_BLACK)
                && !seeded_map[b.pixel_index]) begin
            seeded_map[b.pixel_index] = 1'b1;
            seeded_list.push_back(b.pixel_index);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predicted = pixel_after(b);
        color_q.push_back(literal ? lit_want : predicted);
        n_beats++;
        @(negedge clk);
    endtask

    // Step registers change only once the block has drained.
    task automatic set_step(input t_reg_idx sel, input logic [7:0] val);
        in_valid <= 1'b0;
        while (color_q.size() != 0) @(negedge clk);
        repeat (6) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (sel == REG_ADVANCE_STEP) model_adv = val;
        else model_seed = val;
        n_reg_writes++;
    endtask

    task automatic run_phase(input int in_pct, input int out_pct, input logic [7:0] adv,
                             input logic [7:0] seed, input int beats);
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        set_step(REG_ADVANCE_STEP, adv);
        set_step(REG_SEED_STEP, seed);
        repeat (beats) offer_beat(pick_beat(), 1'b0, NO_WANT);
    endtask

    // Receiver: random back-pressure, plus two long hold-offs while the sender keeps going.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (holds_done < 2 && n_results >= (holds_done + 1) * 500) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            n_results++;
            if (color_q.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("unexpected result beat: idx %0d rgb %0d/%0d/%0d phase %0d",
                             out_beat.out_index, out_beat.red, out_beat.green,
                             out_beat.blue, out_beat.phase);
            end else begin
                want = color_q.pop_front();
                if (out_beat.out_index !== want.out_index || out_beat.red !== want.red
                        || out_beat.green !== want.green || out_beat.blue !== want.blue
                        || out_beat.phase !== want.phase) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("result %0d: want idx %0d rgb %0d/%0d/%0d phase %0d, got %s",
                                 n_results, want.out_index, want.red, want.green,
                                 want.blue, want.phase,
                                 $sformatf("idx %0d rgb %0d/%0d/%0d phase %0d",
                                           out_beat.out_index, out_beat.red,
                                           out_beat.green, out_beat.blue, out_beat.phase));
                end
            end
            if (out_beat.phase <= PHASE_GREEN_DOWN) phases_seen[out_beat.phase] = 1'b1;
        end
    end

    always @(posedge clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d beats outstanding",
                     n_cycles, color_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_beat      = '0;
        out_ready    = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        model_gen    = '0;
        model_adv    = RST_ADVANCE_STEP;
        model_seed   = RST_SEED_STEP;
        in_idle_pct  = 37;
        out_idle_pct = 79;
        sweep_next   = 0;
        sweep_left   = 0;
        hold_left    = 0;
        holds_done   = 0;
        n_beats      = 0;
        n_results    = 0;
        n_fail       = 0;
        n_reg_writes = 0;
        n_cycles     = 0;
        phases_seen  = '0;
        foreach (model_px[i]) model_px[i] = '0;
        foreach (seeded_map[i]) seeded_map[i] = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int row = 0; row < PLAN_ROWS; row++) begin
            if (plan[row].kind == ROW_REG)
                set_step(plan[row].reg_sel, plan[row].reg_val);
            else
                offer_beat(plan[row].beat, plan[row].kind == ROW_LITERAL, plan[row].want);
        end

        // The first random stretch opens with a sweep over every pixel, so all are seeded.
        sweep_next = 0;
        sweep_left = PIXELS;
        run_phase(37, 79, 8'd255, 8'd255, 456);
        run_phase(37, 79, 8'd1, 8'd1, 250);
        run_phase(79, 37, 8'($urandom_range(254, 2)), 8'($urandom_range(254, 2)), 300);
        run_phase(79, 37, 8'd0, 8'd0, 60);
        run_phase(79, 37, 8'd128, 8'd3, 200);
        run_phase(0, 0, 8'd255, 8'd1, 300);
        run_phase(0, 0, 8'($urandom_range(254, 2)), 8'($urandom_range(254, 2)), 300);

        in_valid <= 1'b0;
        while (color_q.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Sent %0d command beats and checked %0d result beats across %0d step writes.",
                 n_beats, n_results, n_reg_writes);
        $display("Receiver hold-offs: %0d; rainbow phases seen (bit per phase): %b.",
                 holds_done, phases_seen);
        if (n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatching or unexpected result beats", n_fail);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/rpa_pkg.sv
hdl/rpa_ctrl.sv
hdl/rpa_datapath.sv
hdl/rainbow_pixel_animator.sv
tb/tb_top.sv
